FILE: sv/sctw_pkg.sv
// Shared constants, types and the quarter-wave sine table for the waveform generator.
package sctw_pkg;

  localparam int PHASE_W    = 32;
  localparam int TAB_BITS   = 10;
  localparam int AMP_W      = 15;
  localparam int STEP_W     = 32;
  localparam int IDX_W      = 32;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int WAVE_W     = 2;

  localparam int QTR_N     = 1 << TAB_BITS;
  localparam int ROM_DEPTH = QTR_N + 1;
  localparam int ROM_AW    = TAB_BITS + 1;
  localparam int Q15_W     = 15;
  localparam int Q15_MAX   = 32767;
  localparam int BIAS_W    = 16;

  // triangle phase inside a quarter, normalized to 30 bits
  localparam int FRAC_W  = 30;
  localparam int RFULL_W = PHASE_W - 2;
  localparam int MUL_W   = FRAC_W;
  localparam int PROD_W  = AMP_W + MUL_W;
  localparam int RND_W   = PROD_W + 1;
  localparam int SA_W    = RND_W - Q15_W;
  localparam int SS_W    = SA_W + 1;
  localparam int A2_W    = SS_W - Q15_W;
  localparam int QUO_W   = SA_W + 1;
  localparam int D_W     = RND_W - FRAC_W;
  localparam int TRI_W   = (AMP_W + 2 > SAMPLE_W) ? AMP_W + 2 : SAMPLE_W;

  localparam logic [PHASE_W-1:0] PHASE_QTR  = {2'b01, {(PHASE_W-2){1'b0}}};
  localparam logic [RND_W-1:0]   TRI_HALF   = {{(RND_W-FRAC_W){1'b0}}, 1'b1,
                                               {(FRAC_W-1){1'b0}}};
  localparam logic [RND_W-1:0]   SINE_HALF  = RND_W'((Q15_MAX - 1) / 2);
  localparam logic [BIAS_W-1:0]  BIAS_MID   = BIAS_W'(Q15_MAX);
  localparam logic [SS_W-1:0]    DIV_LIMIT  = SS_W'(Q15_MAX);

  localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(10);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(536871);

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE = 2'd0,
    WAVE_COS  = 2'd1,
    WAVE_TRI  = 2'd2
  } wave_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_TYPE  = 2'd0,
    REG_AMPLITUDE  = 2'd1,
    REG_PHASE_STEP = 2'd2
  } cfg_reg_t;

  typedef logic [Q15_W-1:0] q15_t;
  typedef q15_t sine_tab_t [ROM_DEPTH];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // two more powers of x in Q30
  function automatic logic [63:0] taylor_pow(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // sin(i/QTR_N * pi/2) scaled to full Q15 scale, evaluated at elaboration
  function automatic q15_t sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    x    = (HALF_PI_Q30 * 64'(i) + 64'(QTR_N / 2)) >> TAB_BITS;
    term = x;
    acc  = signed'(x);
    term = taylor_pow(term, x) / 64'd6;   acc = acc - signed'(term);
    term = taylor_pow(term, x) / 64'd20;  acc = acc + signed'(term);
    term = taylor_pow(term, x) / 64'd42;  acc = acc - signed'(term);
    term = taylor_pow(term, x) / 64'd72;  acc = acc + signed'(term);
    term = taylor_pow(term, x) / 64'd110; acc = acc - signed'(term);
    term = taylor_pow(term, x) / 64'd156; acc = acc + signed'(term);
    term = taylor_pow(term, x) / 64'd210; acc = acc - signed'(term);
    term = taylor_pow(term, x) / 64'd272; acc = acc + signed'(term);
    if (acc < 0) begin
      acc = 64'sd0;
    end
    v = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'(Q15_MAX)) begin
      v = 64'(Q15_MAX);
    end
    return v[Q15_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
      tab[i] = sine_entry(i);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: sv/sine_cosine_triangle_wave_generator.sv
// Top level of the sine / cosine / triangle waveform generator.
//
// Every transaction on the input channel (in_valid/in_ready, field restart)
// produces exactly one transaction on the output channel (out_valid/out_ready,
// fields sample_value and sample_index). The sample is the selected waveform
// at the current phase, offset to span 0..2*amplitude; the phase accumulator
// then advances by phase_step. restart=1 zeroes phase and index first.
// Registers are written through cfg_write_en/cfg_index/cfg_data; the user must
// write them only while no transaction is in flight; the block itself does
// not enforce it. Pipeline: input stage, sine ROM read, multiply, rounding add,
// reciprocal fold, output register.
// Throughput: one sample per clock; each stage holds its item only while the
// stage after it is full and stalled, so bubbles close up and in_ready stays
// high until every stage holds an item behind a stalled receiver.
// Reset clears all valid flags, the phase accumulator, the sample counter
// and restores the register defaults (sine, amplitude 10, step 536871).
module sine_cosine_triangle_wave_generator
  import sctw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   sample_value,
  output logic [IDX_W-1:0]      sample_index,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WAVE_W-1:0]  wave_type;
  logic [AMP_W-1:0]   amplitude;
  logic [STEP_W-1:0]  phase_step;
  logic [PHASE_W-1:0] phase_acc;
  logic [IDX_W-1:0]   sample_cnt;

  logic is_tri, is_cos;
  logic in_fire;
  logic en1, en2, en3, en4, en5, en_out;
  logic v1, v2, v3, v4, v5;

  // stage registers
  logic [PHASE_W-1:0] phase1;
  logic [IDX_W-1:0]   idx1, idx2, idx3, idx4, idx5;
  q15_t               mag2;
  logic [1:0]         quad2, quad3, quad4, quad5;
  logic [FRAC_W-1:0]  frac2;
  logic [PROD_W-1:0]  prod3;
  logic [RND_W-1:0]   rnd4;
  logic [SA_W-1:0]    quo_hi5;
  logic [SS_W-1:0]    fold5;
  logic [D_W-1:0]     tri_d5;

  // combinational
  logic [PHASE_W-1:0]         phase0;
  logic [PHASE_W+STEP_W-1:0]  phase_sum;
  logic [IDX_W-1:0]           idx0;
  logic [TAB_BITS-1:0]        tab_addr;
  logic [ROM_AW-1:0]          rom_addr;
  logic [RFULL_W+FRAC_W-1:0]  frac_ext;
  logic [BIAS_W-1:0]          biased;
  logic [MUL_W-1:0]           mul_op;
  logic [PROD_W-1:0]          prod_c;
  logic [A2_W-1:0]            a2;
  logic                       fold_carry;
  logic [QUO_W-1:0]           quo;
  logic [TRI_W-1:0]           amp_x, d_x, tri_val;
  logic [SAMPLE_W-1:0]        sample_next;

  assign is_tri = (wave_type == WAVE_TRI);
  assign is_cos = (wave_type == WAVE_COS);

  // a stage loads when it is empty or its content moves on
  assign en_out   = !out_valid || out_ready;
  assign en5      = !v5 || en_out;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign in_fire  = in_valid && in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type  <= WAVE_SINE;
      amplitude  <= AMP_RESET;
      phase_step <= STEP_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_WAVE_TYPE:  wave_type  <= cfg_data[WAVE_W-1:0];
        REG_AMPLITUDE:  amplitude  <= cfg_data[AMP_W-1:0];
        REG_PHASE_STEP: phase_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: phase and index for this sample
  assign phase0    = restart ? '0 : phase_acc;
  assign idx0      = restart ? '0 : sample_cnt;
  assign phase_sum = (PHASE_W+STEP_W)'(phase0) + (PHASE_W+STEP_W)'(phase_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      sample_cnt <= '0;
    end else if (in_fire) begin
      phase_acc  <= phase_sum[PHASE_W-1:0];
      sample_cnt <= idx0 + IDX_W'(1);
    end
  end

  // stage 1: phase to look up (cosine reads the sine a quarter turn ahead)
  always_ff @(posedge clk) begin
    if (en1) begin
      phase1 <= is_cos ? phase0 + PHASE_QTR : phase0;
      idx1   <= idx0;
    end
  end

  // stage 2: table read, mirrored in odd quadrants
  assign tab_addr = phase1[PHASE_W-3 -: TAB_BITS];
  assign rom_addr = phase1[PHASE_W-2] ? ROM_AW'(QTR_N) - ROM_AW'(tab_addr)
                                      : ROM_AW'(tab_addr);
  assign frac_ext = {phase1[RFULL_W-1:0], {FRAC_W{1'b0}}};

  sctw_sine_rom u_rom (
    .clk  (clk),
    .en   (en2),
    .addr (rom_addr),
    .data (mag2)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      quad2 <= phase1[PHASE_W-1 -: 2];
      frac2 <= frac_ext[RFULL_W+FRAC_W-1 -: FRAC_W];
      idx2  <= idx1;
    end
  end

  // stage 3: one shared multiplier, amplitude times biased sine or ramp
  assign biased = quad2[1] ? BIAS_MID - BIAS_W'(mag2) : BIAS_MID + BIAS_W'(mag2);
  assign mul_op = is_tri ? frac2 : MUL_W'(biased);
  assign prod_c = amplitude * mul_op;

  always_ff @(posedge clk) begin
    if (en3) begin
      prod3 <= prod_c;
      quad3 <= quad2;
      idx3  <= idx2;
    end
  end

  // stage 4: rounding offset
  always_ff @(posedge clk) begin
    if (en4) begin
      rnd4  <= RND_W'(prod3) + (is_tri ? TRI_HALF : SINE_HALF);
      quad4 <= quad3;
      idx4  <= idx3;
    end
  end

  // stage 5: divide by 2^15-1 via m = hi*(2^15-1) + hi + lo, first fold
  always_ff @(posedge clk) begin
    if (en5) begin
      quo_hi5 <= rnd4[RND_W-1:Q15_W];
      fold5   <= SS_W'(rnd4[RND_W-1:Q15_W]) + SS_W'(rnd4[Q15_W-1:0]);
      tri_d5  <= rnd4[RND_W-1:FRAC_W];
      quad5   <= quad4;
      idx5    <= idx4;
    end
  end

  // second fold leaves a remainder below twice the divisor: one compare
  assign a2         = fold5[SS_W-1:Q15_W];
  assign fold_carry = (SS_W'(a2) + SS_W'(fold5[Q15_W-1:0])) >= DIV_LIMIT;
  assign quo        = QUO_W'(quo_hi5) + QUO_W'(a2) + QUO_W'(fold_carry);

  // triangle: rise from mid, fall through mid to zero, rise back to mid
  assign amp_x = TRI_W'(amplitude);
  assign d_x   = TRI_W'(tri_d5);
  always_comb begin
    if (quad5[1]) begin
      tri_val = quad5[0] ? d_x : amp_x - d_x;
    end else begin
      tri_val = quad5[0] ? (amp_x + amp_x) - d_x : amp_x + d_x;
    end
  end

  assign sample_next = is_tri ? tri_val[SAMPLE_W-1:0] : quo[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (en_out) begin
      sample_value <= sample_next;
      sample_index <= idx5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= in_valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      if (en5)    v5        <= v4;
      if (en_out) out_valid <= v5;
    end
  end

endmodule

FILE: sv/sctw_sine_rom.sv
// Quarter-wave sine ROM with registered read.
module sctw_sine_rom
  import sctw_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ROM_AW-1:0] addr,
  output q15_t              data
);

  always_ff @(posedge clk) begin
    if (en) begin
      data <= SINE_TAB[addr];
    end
  end

endmodule

FILE: tb/testbench.sv
// Testbench for the sine / cosine / triangle waveform generator: predicts and checks every sample.
`timescale 1ns / 1ps
module testbench;
  import sctw_pkg::*;

  localparam int TAB_N = 1 << TAB_BITS;
  localparam logic [63:0] HALF_PI_FRAC = 64'd1686629713;  // pi/2 in Q30
  localparam logic [WAVE_W-1:0] WAVE_SPARE = 2'd3;         // unused code, decodes as sine
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] EIGHTH_TURN = 32'h2000_0000;
  localparam int MAX_GAP = 14;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 50;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]    index;
  } sample_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SAMPLE_W-1:0]   sample_value;
  logic [IDX_W-1:0]      sample_index;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WAVE_TYPE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // generator shadow: registers and running state
  logic [WAVE_W-1:0]  cur_wave;
  logic [AMP_W-1:0]   cur_amp;
  logic [STEP_W-1:0]  cur_step;
  logic [PHASE_W-1:0] gen_phase;
  logic [IDX_W-1:0]   gen_count;
  logic [Q15_W-1:0]   quarter_sine [TAB_N+1];

  logic    tick_queue [$];
  sample_t pending_samples [$];
  sample_t head;

  bit src_idle = 1'b0;
  bit snk_idle = 1'b0;
  int tick_gap = 0;
  int sink_stall = 0;
  int ticks_queued = 0;
  int samples_seen = 0;
  int restarts_sent = 0;
  int settings_used = 0;
  int mismatches = 0;
  int cycle_count = 0;

  sine_cosine_triangle_wave_generator uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .sample_index (sample_index),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // sin(i/TAB_N * pi/2) at Q15 full scale, Taylor series in Q30
  function automatic logic [Q15_W-1:0] sine_point(input int i);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] v;
    longint      acc;
    x = (HALF_PI_FRAC * 64'(i) + 64'(TAB_N / 2)) / 64'(TAB_N);
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (64'(acc) * 64'(Q15_MAX) + (64'd1 << 29)) >> 30;
    if (v > 64'(Q15_MAX)) begin
      v = 64'(Q15_MAX);
    end
    return v[Q15_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] sine_level(input logic [PHASE_W-1:0] ph,
                                                     input logic [AMP_W-1:0] a);
    logic [1:0]          quad;
    logic [TAB_BITS-1:0] addr;
    logic [63:0]         mag;
    logic [63:0]         biased;
    quad = ph[PHASE_W-1 -: 2];
    addr = ph[PHASE_W-3 -: TAB_BITS];
    mag = quad[0] ? 64'(quarter_sine[TAB_N - int'(addr)]) : 64'(quarter_sine[addr]);
    biased = quad[1] ? 64'(Q15_MAX) - mag : 64'(Q15_MAX) + mag;
    return SAMPLE_W'((64'd2 * 64'(a) * biased + 64'(Q15_MAX)) / 64'(2 * Q15_MAX));
  endfunction

  // mid level, up to the peak, down to zero, back to mid
  function automatic logic [SAMPLE_W-1:0] triangle_level(input logic [PHASE_W-1:0] ph,
                                                         input logic [AMP_W-1:0] a);
    logic [63:0] amp;
    logic [63:0] d;
    amp = 64'(a);
    d = (amp * 64'(ph[PHASE_W-3:0]) + (64'd1 << 29)) >> 30;
    case (ph[PHASE_W-1 -: 2])
      2'd0:    return SAMPLE_W'(amp + d);
      2'd1:    return SAMPLE_W'(2 * amp - d);
      2'd2:    return SAMPLE_W'(amp - d);
      default: return SAMPLE_W'(d);
    endcase
  endfunction

  function automatic void predict_sample(input logic rs);
    sample_t s;
    if (rs) begin
      gen_phase = '0;
      gen_count = '0;
    end
    case (cur_wave)
      WAVE_TRI: s.value = triangle_level(gen_phase, cur_amp);
      WAVE_COS: s.value = sine_level(gen_phase + QUARTER_TURN, cur_amp);
      default:  s.value = sine_level(gen_phase, cur_amp);
    endcase
    s.index = gen_count;
    pending_samples.push_back(s);
    gen_phase = gen_phase + cur_step;
    gen_count = gen_count + 1'b1;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_WAVE_TYPE:  cur_wave = data[WAVE_W-1:0];
      REG_AMPLITUDE:  cur_amp = data[AMP_W-1:0];
      REG_PHASE_STEP: cur_step = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_ticks(input int n, input bit lead_restart, input int restart_odds);
    for (int i = 0; i < n; i++) begin
      if (i == 0 && lead_restart) begin
        tick_queue.push_back(1'b1);
      end else begin
        tick_queue.push_back(restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
      end
      ticks_queued++;
    end
  endtask

  // hold off new ticks until every queued transaction has produced its sample
  task automatic wait_for_drain();
    do @(posedge clk);
    while (samples_seen < ticks_queued);
  endtask

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sample(restart);
        if (restart) restarts_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tick_gap > 0) begin
          tick_gap--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          restart <= tick_queue.pop_front();
          in_valid <= 1'b1;
          tick_gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // sample monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        samples_seen++;
        if (pending_samples.size() == 0) begin
          $error("unexpected sample: sample_value %0d sample_index %0d",
                 sample_value, sample_index);
          mismatches++;
        end else begin
          head = pending_samples.pop_front();
          if (sample_value !== head.value) begin
            $error("sample_value: expected %0d, got %0d", head.value, sample_value);
            mismatches++;
          end
          if (sample_index !== head.index) begin
            $error("sample_index: expected %0d, got %0d", head.index, sample_index);
            mismatches++;
          end
        end
        sink_stall = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at cycle limit %0d, %0d samples outstanding",
               CYCLE_LIMIT, ticks_queued - samples_seen);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int                  pick;
    logic [31:0]         junk;
    logic [AMP_W-1:0]    amp_pick;
    logic [STEP_W-1:0]   step_pick;
    logic [WAVE_W-1:0]   wave_pick;
    for (int i = 0; i <= TAB_N; i++) begin
      quarter_sine[i] = sine_point(i);
    end
    cur_wave = WAVE_SINE;
    cur_amp = AMP_RESET;
    cur_step = STEP_RESET;
    gen_phase = '0;
    gen_count = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset defaults, with a restart in the middle
    settings_used++;
    queue_ticks(2, 1'b0, 0);
    queue_ticks(2, 1'b1, 0);
    wait_for_drain();

    // quarter-turn steps land on each quadrant boundary
    settings_used++;
    write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_SINE));
    write_reg(REG_AMPLITUDE, CFG_DATA_W'(Q15_MAX));
    write_reg(REG_PHASE_STEP, QUARTER_TURN);
    queue_ticks(5, 1'b1, 0);
    wait_for_drain();

    settings_used++;
    write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_COS));
    queue_ticks(5, 1'b1, 0);
    wait_for_drain();

    settings_used++;
    write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_TRI));
    write_reg(REG_PHASE_STEP, EIGHTH_TURN);
    queue_ticks(8, 1'b1, 0);
    wait_for_drain();

    settings_used++;
    write_reg(REG_WAVE_TYPE, CFG_DATA_W'(WAVE_SPARE));
    write_reg(REG_AMPLITUDE, '0);
    write_reg(REG_PHASE_STEP, '1);
    queue_ticks(3, 1'b1, 0);
    wait_for_drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      src_idle = p[0];
      snk_idle = p[1];
      settings_used++;
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      wave_pick = WAVE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0:       amp_pick = '0;
        1:       amp_pick = AMP_W'(Q15_MAX);
        default: amp_pick = AMP_W'($urandom);
      endcase
      pick = (p == 0) ? 0 : $urandom_range(0, 5);
      case (pick)
        0:       step_pick = '0;
        1:       step_pick = '1;
        2:       step_pick = $urandom_range(1, 1 << 24);
        3:       step_pick = QUARTER_TURN + $urandom_range(0, 255) - 128;
        default: step_pick = $urandom;
      endcase
      if (p < 2 || $urandom_range(0, 3) != 0) begin
        write_reg(REG_WAVE_TYPE, {junk[31:WAVE_W], wave_pick});
      end
      if (p < 2 || $urandom_range(0, 3) != 0) begin
        write_reg(REG_AMPLITUDE, {junk[31:AMP_W], amp_pick});
      end
      if (p < 2 || $urandom_range(0, 3) != 0) begin
        write_reg(REG_PHASE_STEP, step_pick);
      end
      queue_ticks(ITEMS_PER_PHASE, 1'($urandom_range(0, 1)), 25);
      wait_for_drain();
    end

    repeat (8) @(posedge clk);
    if (pending_samples.size() != 0) begin
      $error("%0d predicted samples never appeared", pending_samples.size());
      mismatches++;
    end
    $display("Checked %0d samples from %0d ticks (%0d restarts) over %0d register settings,",
             samples_seen, ticks_queued, restarts_sent, settings_used);
    $display("covering all four wave codes, zero and full-scale amplitude, zero and max step.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sine_cosine_triangle_wave_generator.f
sv/sctw_pkg.sv
sv/sctw_sine_rom.sv
sv/sine_cosine_triangle_wave_generator.sv
tb/testbench.sv
